// ===== rtl/rmst_pkg.sv =====
// Shared types, field widths and helpers for the range maximum segment tree.
package rmst_pkg;

    localparam int DATA_W         = 64;
    localparam int POSITION_W     = 10;
    localparam int RANGE_LOW_W    = 10;
    localparam int RANGE_HIGH_W   = 11;
    localparam int DEF_LEAF_COUNT = 1024;

    // Input tdata layout, lowest bit first
    localparam int POSITION_LSB   = 0;
    localparam int VALUE_LSB      = POSITION_LSB + POSITION_W;
    localparam int RANGE_LOW_LSB  = VALUE_LSB + DATA_W;
    localparam int RANGE_HIGH_LSB = RANGE_LOW_LSB + RANGE_LOW_W;
    localparam int S_PACKED_W     = RANGE_HIGH_LSB + RANGE_HIGH_W;
    localparam int S_TDATA_W      = ((S_PACKED_W + 7) / 8) * 8;
    localparam int M_TDATA_W      = DATA_W;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_LEAF,
        ST_WR_UP,
        ST_Q_LO,
        ST_Q_HI,
        ST_Q_DRAIN
    } state_t;

    // Signed maximum of two node values
    function automatic logic signed [DATA_W-1:0] smax(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return (a >= b) ? a : b;
    endfunction

endpackage

// ===== rtl/range_max_segment_tree.sv =====
// Range maximum segment tree: point writes and half-open range max queries over one node RAM.
//
// Usage:
//   Input stream (s_axis_*): one transaction per operation. tuser selects the
//   operation (write one leaf or query a range); tdata carries position, value,
//   range_low and range_high. A write gives no result; a query gives exactly one
//   result transaction on the output stream (m_axis_*) carrying
//   max(0, largest leaf value in [range_low, range_high)). range_high beyond the
//   leaf count is clamped, an empty range returns 0, a write position at or
//   beyond the leaf count is dropped.
//   Timing: one operation at a time. A write stores the leaf, then climbs the tree
//   one level per step (read sibling, write parent) up to the root. A query
//   walks up from both range ends; the single read port of the node RAM allows
//   at most two node reads per level, one per cycle.
//   Reset: aresetn (synchronous, active low) starts a clearing pass that zeroes
//   all 2 * LEAF_COUNT nodes, one per cycle; s_axis_tready stays low meanwhile.
//   Stall: a finished result waits in the output register; the next operation
//   is accepted meanwhile and only a query that finishes while the register is
//   still full holds in its last step until the receiver takes the result.
module range_max_segment_tree #(
    parameter int LEAF_COUNT = rmst_pkg::DEF_LEAF_COUNT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: position[9:0], value[73:10], range_low[83:74], range_high[94:84], zero pad
    input  logic [rmst_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: operation (0 = write, 1 = query)
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: range_max[63:0]
    output logic [rmst_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int NODE_COUNT = 2 * LEAF_COUNT;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int CNT_W      = NODE_W + 1;
    localparam int WIDE_W     = (CNT_W > rmst_pkg::RANGE_HIGH_W) ? CNT_W : rmst_pkg::RANGE_HIGH_W;
    localparam logic [CNT_W-1:0]  LEAF_C    = CNT_W'(LEAF_COUNT);
    localparam logic [WIDE_W-1:0] LEAF_WIDE = WIDE_W'(LEAF_COUNT);
    localparam logic [CNT_W-1:0]  ROOT_C    = CNT_W'(1);
    localparam logic [NODE_W-1:0] CLR_LAST  = NODE_W'(NODE_COUNT - 1);

    // Node RAM, node k holds max of nodes 2k and 2k+1; leaf i sits at node LEAF_COUNT + i
    logic [rmst_pkg::DATA_W-1:0] mem [NODE_COUNT];

    rmst_pkg::state_t state_reg, state_next;

    logic [NODE_W-1:0]                  clr_reg, clr_next;
    logic [CNT_W-1:0]                   lo_reg, lo_next;      // node index during a write
    logic [CNT_W-1:0]                   hi_reg, hi_next;
    logic signed [rmst_pkg::DATA_W-1:0] acc_reg, acc_next;    // leaf value or running best
    logic                               pend_reg, pend_next;  // query read lands this cycle
    logic signed [rmst_pkg::DATA_W-1:0] rd_data_reg;
    logic                               m_valid_reg, m_valid_next;
    logic [rmst_pkg::DATA_W-1:0]        m_data_reg, m_data_next;

    logic                        mem_we, mem_re;
    logic [NODE_W-1:0]           mem_waddr, mem_raddr;
    logic [rmst_pkg::DATA_W-1:0] mem_wdata;

    // Input field decode
    logic [rmst_pkg::POSITION_W-1:0]    in_position;
    logic signed [rmst_pkg::DATA_W-1:0] in_value;
    logic [rmst_pkg::RANGE_LOW_W-1:0]   in_range_low;
    logic [rmst_pkg::RANGE_HIGH_W-1:0]  in_range_high;
    logic                               in_accept;
    logic                               pos_hit;
    logic [WIDE_W-1:0]                  hi_wide, hi_clamp_wide, lo_wide;
    logic [CNT_W-1:0]                   hi_clamp;

    // Shared datapath values
    logic signed [rmst_pkg::DATA_W-1:0] acc_merge;
    logic [CNT_W-1:0]                   parent;
    logic [CNT_W-1:0]                   hi_dec;
    logic                               out_free;

    assign in_position   = s_axis_tdata[rmst_pkg::POSITION_LSB +: rmst_pkg::POSITION_W];
    assign in_value      = s_axis_tdata[rmst_pkg::VALUE_LSB +: rmst_pkg::DATA_W];
    assign in_range_low  = s_axis_tdata[rmst_pkg::RANGE_LOW_LSB +: rmst_pkg::RANGE_LOW_W];
    assign in_range_high = s_axis_tdata[rmst_pkg::RANGE_HIGH_LSB +: rmst_pkg::RANGE_HIGH_W];

    assign s_axis_tready = (state_reg == rmst_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign pos_hit       = (WIDE_W'(in_position) < LEAF_WIDE);
    assign hi_wide       = WIDE_W'(in_range_high);
    assign lo_wide       = WIDE_W'(in_range_low);
    assign hi_clamp_wide = (hi_wide > LEAF_WIDE) ? LEAF_WIDE : hi_wide;
    assign hi_clamp      = hi_clamp_wide[CNT_W-1:0];

    assign acc_merge = rmst_pkg::smax(acc_reg, rd_data_reg);
    assign parent    = lo_reg >> 1;
    assign hi_dec    = hi_reg[0] ? (hi_reg - CNT_W'(1)) : hi_reg;
    assign out_free  = !m_valid_reg || m_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rmst_pkg::ST_CLEAR: begin
                if (clr_reg == CLR_LAST) state_next = rmst_pkg::ST_IDLE;
            end
            rmst_pkg::ST_IDLE: begin
                if (in_accept) begin
                    if (s_axis_tuser == rmst_pkg::OP_QUERY) begin
                        state_next = rmst_pkg::ST_Q_LO;
                    end else if (pos_hit) begin
                        state_next = rmst_pkg::ST_WR_LEAF;
                    end
                end
            end
            rmst_pkg::ST_WR_LEAF: state_next = rmst_pkg::ST_WR_UP;
            rmst_pkg::ST_WR_UP: begin
                if (parent == ROOT_C) state_next = rmst_pkg::ST_IDLE;
            end
            rmst_pkg::ST_Q_LO: begin
                state_next = (lo_reg < hi_reg) ? rmst_pkg::ST_Q_HI : rmst_pkg::ST_Q_DRAIN;
            end
            rmst_pkg::ST_Q_HI: state_next = rmst_pkg::ST_Q_LO;
            rmst_pkg::ST_Q_DRAIN: begin
                if (out_free) state_next = rmst_pkg::ST_IDLE;
            end
            default: state_next = rmst_pkg::ST_CLEAR;
        endcase
    end

    // Datapath and RAM control
    always_comb begin
        clr_next     = clr_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        acc_next     = pend_reg ? acc_merge : acc_reg;
        pend_next    = 1'b0;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_waddr    = clr_reg;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = lo_reg[NODE_W-1:0];
        case (state_reg)
            rmst_pkg::ST_CLEAR: begin
                mem_we   = 1'b1;
                clr_next = clr_reg + NODE_W'(1);
            end
            rmst_pkg::ST_IDLE: begin
                if (in_accept) begin
                    if (s_axis_tuser == rmst_pkg::OP_QUERY) begin
                        acc_next = '0;
                        hi_next  = hi_clamp + LEAF_C;
                        // empty range: start with lo == hi so the walk ends at once
                        lo_next  = (lo_wide >= hi_clamp_wide) ? (hi_clamp + LEAF_C)
                                                              : (CNT_W'(in_range_low) + LEAF_C);
                    end else begin
                        acc_next = in_value;
                        lo_next  = CNT_W'(in_position) + LEAF_C;
                    end
                end
            end
            rmst_pkg::ST_WR_LEAF: begin
                // write leaf, fetch its sibling
                mem_we    = 1'b1;
                mem_waddr = lo_reg[NODE_W-1:0];
                mem_wdata = acc_reg;
                mem_re    = 1'b1;
                mem_raddr = lo_reg[NODE_W-1:0] ^ NODE_W'(1);
            end
            rmst_pkg::ST_WR_UP: begin
                // parent = max(this node, sibling); fetch the parent's sibling
                mem_we    = 1'b1;
                mem_waddr = parent[NODE_W-1:0];
                mem_wdata = acc_merge;
                acc_next  = acc_merge;
                lo_next   = parent;
                mem_re    = (parent != ROOT_C);
                mem_raddr = parent[NODE_W-1:0] ^ NODE_W'(1);
            end
            rmst_pkg::ST_Q_LO: begin
                if ((lo_reg < hi_reg) && lo_reg[0]) begin
                    mem_re    = 1'b1;
                    mem_raddr = lo_reg[NODE_W-1:0];
                    pend_next = 1'b1;
                    lo_next   = lo_reg + CNT_W'(1);
                end
            end
            rmst_pkg::ST_Q_HI: begin
                if (hi_reg[0]) begin
                    mem_re    = 1'b1;
                    mem_raddr = hi_dec[NODE_W-1:0];
                    pend_next = 1'b1;
                end
                lo_next = lo_reg >> 1;
                hi_next = hi_dec >> 1;
            end
            rmst_pkg::ST_Q_DRAIN: begin
                // last read merges here; hold until the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pend_reg ? acc_merge : acc_reg;
                end
            end
            default: begin
                acc_next = acc_reg;
            end
        endcase
    end

    // Node RAM: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rmst_pkg::ST_CLEAR;
            clr_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

    // Result only ever comes out of the final query step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(state_reg == rmst_pkg::ST_Q_DRAIN))
        else $error("result loaded outside query drain");

    // Write walk never climbs above the root
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rmst_pkg::ST_WR_UP) |-> (lo_reg >= CNT_W'(2)))
        else $error("write walk passed the root");

    // No operation is taken while the node RAM is being cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rmst_pkg::ST_CLEAR) |-> !s_axis_tready)
        else $error("input accepted during clearing pass");

    // A pending query read only follows a read issue in a query step
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> ($past(mem_re) && ($past(state_reg) == rmst_pkg::ST_Q_LO
                                        || $past(state_reg) == rmst_pkg::ST_Q_HI)))
        else $error("query merge without a query read");

endmodule

// ===== test/range_max_segment_tree_checker.sv =====
// Checker for the range max segment tree: tracks the leaf tree and compares query results.
module range_max_segment_tree_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    // tdata: position, value, range_low, range_high, zero pad
    input  logic [rmst_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: operation
    input  logic                           s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: range_max
    input  logic [rmst_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output int                             fail_count,
    output int                             pending_count
);

    localparam int LEAVES = rmst_pkg::DEF_LEAF_COUNT;

    // Node 1 is the root, leaf i sits at node LEAVES + i
    logic signed [rmst_pkg::DATA_W-1:0] node_val [1:2*LEAVES-1];
    logic signed [rmst_pkg::DATA_W-1:0] expected_max_q [$];

    function automatic void store_leaf(int unsigned pos,
                                       logic signed [rmst_pkg::DATA_W-1:0] v);
        int unsigned k;
        if (pos >= LEAVES) return;
        k = LEAVES + pos;
        node_val[k] = v;
        k = k >> 1;
        while (k >= 1) begin
            node_val[k] = (node_val[2*k] >= node_val[2*k+1]) ? node_val[2*k] : node_val[2*k+1];
            k = k >> 1;
        end
    endfunction

    function automatic logic signed [rmst_pkg::DATA_W-1:0] range_peak(int unsigned lo,
                                                                     int unsigned hi);
        logic signed [rmst_pkg::DATA_W-1:0] best;
        best = '0;
        if (hi > LEAVES) hi = LEAVES;
        if (lo >= hi) return '0;
        lo += LEAVES;
        hi += LEAVES;
        while (lo < hi) begin
            if ((lo & 1) != 0) begin
                if (node_val[lo] > best) best = node_val[lo];
                lo++;
            end
            if ((hi & 1) != 0) begin
                hi--;
                if (node_val[hi] > best) best = node_val[hi];
            end
            lo = lo >> 1;
            hi = hi >> 1;
        end
        return best;
    endfunction

    always @(posedge aclk) begin
        logic signed [rmst_pkg::DATA_W-1:0] want;
        logic signed [rmst_pkg::DATA_W-1:0] got;
        rmst_pkg::op_t                      op;
        if (!aresetn) begin
            foreach (node_val[i]) node_val[i] = '0;
            expected_max_q.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end else begin
            // Retire the result first: it always belongs to an earlier query
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (expected_max_q.size() == 0) begin
                    $display("%0t: unexpected result transaction, got %0d", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_max_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: range_max mismatch, expected %0d, got %0d",
                                 $time, want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                op = rmst_pkg::op_t'(s_axis_tuser);
                if (op == rmst_pkg::OP_WRITE)
                    store_leaf(int'(s_axis_tdata[rmst_pkg::POSITION_LSB +: rmst_pkg::POSITION_W]),
                               s_axis_tdata[rmst_pkg::VALUE_LSB +: rmst_pkg::DATA_W]);
                else
                    expected_max_q.push_back(range_peak(
                        int'(s_axis_tdata[rmst_pkg::RANGE_LOW_LSB +: rmst_pkg::RANGE_LOW_W]),
                        int'(s_axis_tdata[rmst_pkg::RANGE_HIGH_LSB +: rmst_pkg::RANGE_HIGH_W])));
            end
            pending_count <= expected_max_q.size();
        end
    end

endmodule

// ===== test/range_max_segment_tree_tb.sv =====
// Testbench top for the range max segment tree: stimulus, receiver stalls, watchdog and verdict.
module range_max_segment_tree_tb;

    localparam int LEAVES       = rmst_pkg::DEF_LEAF_COUNT;
    localparam int RANDOM_OPS   = 1130;
    // Must lie far beyond the clearing pass and a long receiver hold (HOLD_CYCLES)
    localparam int IDLE_LIMIT   = 20000;
    localparam int HOLD_CYCLES  = 400;
    // Wait well past the end of the last query before the verdict
    localparam int DRAIN_CYCLES = 60;
    localparam int BURST_OPS    = 40;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [rmst_pkg::S_TDATA_W-1:0]   s_axis_tdata;
    logic                             s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [rmst_pkg::M_TDATA_W-1:0]   m_axis_tdata;

    int                     fail_count;
    int                     pending_count;
    bit                     pressure_req;

    range_max_segment_tree dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    range_max_segment_tree_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Favor a small window of leaves so that writes and queries overlap often
    function automatic int unsigned pick_leaf();
        if ($urandom_range(0, 9) < 6) return $urandom_range(0, 127);
        return $urandom_range(0, LEAVES - 1);
    endfunction

    function automatic logic [rmst_pkg::DATA_W-1:0] pick_value();
        logic [rmst_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 64'h7FFF_FFFF_FFFF_FFFF;
            1:       v = 64'h8000_0000_0000_0000;
            2:       v = '0;
            3:       v = '1;
            4, 5:    v = 64'($urandom_range(1, 1000));
            6:       v = -64'($urandom_range(1, 1000));
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // Offer one transaction at the falling edge, hold it until accepted, then idle a while.
    // With no idle the next call drives the next item at the following falling edge,
    // so tvalid stays high without being dropped in between.
    task automatic send_op(input rmst_pkg::op_t op, input int unsigned pos,
                           input logic [rmst_pkg::DATA_W-1:0] val, input int unsigned lo,
                           input int unsigned hi, input bit no_gap);
        logic [rmst_pkg::S_TDATA_W-1:0] word;
        int                             gap;
        word = '0;
        word[rmst_pkg::POSITION_LSB   +: rmst_pkg::POSITION_W]   = pos[rmst_pkg::POSITION_W-1:0];
        word[rmst_pkg::VALUE_LSB      +: rmst_pkg::DATA_W]       = val;
        word[rmst_pkg::RANGE_LOW_LSB  +: rmst_pkg::RANGE_LOW_W]  = lo[rmst_pkg::RANGE_LOW_W-1:0];
        word[rmst_pkg::RANGE_HIGH_LSB +: rmst_pkg::RANGE_HIGH_W] = hi[rmst_pkg::RANGE_HIGH_W-1:0];
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= word;
        do @(posedge aclk); while (!s_axis_tready);
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Random operation; unused fields get random content too
    task automatic random_op(input bit query_only, input bit no_gap);
        int unsigned lo;
        int unsigned hi;
        int          r;
        lo = pick_leaf();
        r  = $urandom_range(0, 19);
        if (r == 0)
            hi = $urandom_range(0, lo);               // empty range
        else if (r == 1)
            hi = $urandom_range(LEAVES, 2047);        // end past the last leaf
        else if (r == 2) begin
            lo = 0;
            hi = LEAVES;
        end else
            hi = lo + $urandom_range(1, 64);
        if (!query_only && $urandom_range(0, 1) == 0)
            send_op(rmst_pkg::OP_WRITE, pick_leaf(), pick_value(), $urandom_range(0, 1023),
                    $urandom_range(0, 2047), no_gap);
        else
            send_op(rmst_pkg::OP_QUERY, $urandom_range(0, 1023), {$urandom, $urandom}, lo, hi,
                    no_gap);
    endtask

    // Receiver: random ready runs and stalls, plus one long hold on request
    initial begin
        bit held;
        int stall;
        held          = 1'b0;
        m_axis_tready = 1'b0;
        @(negedge aclk);
        forever begin
            if (pressure_req && !held) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
        end
    end

    // Watchdog: give up once nothing has moved on either channel for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = rmst_pkg::OP_WRITE;
        pressure_req  = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty tree, signed extremes, clamped and empty ranges, overwrites
        send_op(rmst_pkg::OP_QUERY, 10'h3FF, '1, 0, LEAVES, 1'b0);
        send_op(rmst_pkg::OP_WRITE, 0, 64'h7FFF_FFFF_FFFF_FFFF, 10'h3FF, 11'h7FF, 1'b0);
        send_op(rmst_pkg::OP_WRITE, LEAVES - 1, 64'h8000_0000_0000_0000, 0, 0, 1'b0);
        send_op(rmst_pkg::OP_QUERY, 0, '0, 0, LEAVES, 1'b0);
        send_op(rmst_pkg::OP_QUERY, 0, '0, LEAVES - 1, LEAVES, 1'b0);
        send_op(rmst_pkg::OP_QUERY, 0, '0, 1, LEAVES - 1, 1'b0);
        send_op(rmst_pkg::OP_WRITE, LEAVES - 1, 64'd5, 10'h155, 11'h2AA, 1'b1);
        send_op(rmst_pkg::OP_QUERY, 10'h155, '0, 1000, 11'h7FF, 1'b1);
        send_op(rmst_pkg::OP_QUERY, 0, '0, 5, 5, 1'b0);
        send_op(rmst_pkg::OP_QUERY, 0, '0, 10, 3, 1'b0);
        send_op(rmst_pkg::OP_QUERY, 0, '0, LEAVES - 1, LEAVES - 1, 1'b0);
        send_op(rmst_pkg::OP_WRITE, 512, '1, 0, 0, 1'b0);
        send_op(rmst_pkg::OP_QUERY, 0, '0, 512, 513, 1'b0);
        send_op(rmst_pkg::OP_WRITE, 512, 64'd1, 0, 0, 1'b0);
        send_op(rmst_pkg::OP_WRITE, 0, 64'h8000_0000_0000_0000, 0, 0, 1'b0);
        send_op(rmst_pkg::OP_QUERY, 0, '0, 0, 1, 1'b0);
        send_op(rmst_pkg::OP_QUERY, 0, '0, 0, LEAVES, 1'b0);
        send_op(rmst_pkg::OP_WRITE, 511, 64'h4000_0000_0000_0000, 0, 0, 1'b1);
        send_op(rmst_pkg::OP_QUERY, 0, '0, 256, 768, 1'b1);
        send_op(rmst_pkg::OP_QUERY, 0, '0, 0, 11'h7FF, 1'b0);
        send_op(rmst_pkg::OP_WRITE, LEAVES - 1, 64'd0, 0, 0, 1'b0);
        send_op(rmst_pkg::OP_QUERY, 0, '0, 1023, LEAVES, 1'b0);

        // Random mix with periodic stretches without idle cycles
        for (int i = 0; i < RANDOM_OPS; i++) begin
            if (i == RANDOM_OPS / 2) begin
                // Hold the receiver and flood queries so the block backs up
                pressure_req = 1'b1;
                for (int j = 0; j < BURST_OPS; j++) random_op(1'b1, 1'b1);
                i += BURST_OPS;
            end
            random_op(1'b0, (i % 150) < 25);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every expected result, then watch for strays
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
